FILE: src/slt_pkg.sv
// sorted leaf table: shared command, status and state codes
// and the result side-band struct; no dependencies
package slt_pkg;

   localparam int CMD_BITS    = 3;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 16;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_FIND   = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_UPDATE = 3'd3,
      CMD_SCAN   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_NOT_FOUND  = 2'd1,
      STATUS_NEED_SPLIT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DISPATCH,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_REM_SHIFT,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   value_valid;
      logic [COUNT_BITS-1:0]  running_count;
      logic                   last_result;
   } rsp_meta_type;

endpackage

FILE: src/slt_req_if.sv
// sorted leaf table: request channel, one beat per command
// depends on slt_pkg
interface slt_req_if
   import slt_pkg::*;
#(
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) ();
   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   command;
   logic [KEY_BITS-1:0]   search_key;
   logic [VALUE_BITS-1:0] new_value;
   logic [COUNT_BITS-1:0] count_so_far;
   logic [COUNT_BITS-1:0] range_limit;
   logic                  continue_scan;

   modport source (
      output valid, command, search_key, new_value, count_so_far, range_limit,
             continue_scan,
      input  ready
   );
   modport sink (
      input  valid, command, search_key, new_value, count_so_far, range_limit,
             continue_scan,
      output ready
   );
endinterface

FILE: src/slt_rsp_if.sv
// sorted leaf table: response channel, one or more beats per command
// depends on slt_pkg
interface slt_rsp_if
   import slt_pkg::*;
#(
   parameter int VALUE_BITS = 64
) ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [VALUE_BITS-1:0]  found_value;
   logic                   value_valid;
   logic [COUNT_BITS-1:0]  running_count;
   logic                   last_result;

   modport source (
      output valid, status, found_value, value_valid, running_count, last_result,
      input  ready
   );
   modport sink (
      input  valid, status, found_value, value_valid, running_count, last_result,
      output ready
   );
endinterface

FILE: src/slt_ram.sv
// sorted leaf table: entry store, one write and one registered read port
// no package dependencies
module slt_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 128,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/slt_rsp_stage.sv
// sorted leaf table: output register between sequencer and response channel
// depends on slt_pkg
module slt_rsp_stage
   import slt_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rsp_meta_type           meta,
   input  logic [VALUE_BITS-1:0]  value,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [VALUE_BITS-1:0]  rsp_found_value,
   output logic                   rsp_value_valid,
   output logic [COUNT_BITS-1:0]  rsp_running_count,
   output logic                   rsp_last_result
);

   logic                  valid_ff;
   logic                  valid_in;
   rsp_meta_type          meta_ff;
   logic [VALUE_BITS-1:0] value_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         meta_ff  <= meta;
         value_ff <= value;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = meta_ff.status;
   assign rsp_found_value   = value_ff;
   assign rsp_value_valid   = meta_ff.value_valid;
   assign rsp_running_count = meta_ff.running_count;
   assign rsp_last_result   = meta_ff.last_result;

endmodule

FILE: src/slt_ctrl.sv
// sorted leaf table: sequencer for search, shift, scan and response beats
// depends on slt_pkg; drives slt_ram and slt_rsp_stage
module slt_ctrl
   import slt_pkg::*;
#(
   parameter int CAPACITY   = 32,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64,
   parameter int IDX_BITS   = $clog2(CAPACITY),
   parameter int WORD_BITS  = KEY_BITS + VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_BITS-1:0]   req_command,
   input  logic [KEY_BITS-1:0]   req_search_key,
   input  logic [VALUE_BITS-1:0] req_new_value,
   input  logic [COUNT_BITS-1:0] req_count_so_far,
   input  logic [COUNT_BITS-1:0] req_range_limit,
   input  logic                  req_continue_scan,
   output logic                  mem_wr_en,
   output logic [IDX_BITS-1:0]   mem_wr_addr,
   output logic [WORD_BITS-1:0]  mem_wr_data,
   output logic                  mem_rd_en,
   output logic [IDX_BITS-1:0]   mem_rd_addr,
   input  logic [WORD_BITS-1:0]  mem_rd_data,
   input  logic                  rsp_free,
   output logic                  rsp_load,
   output rsp_meta_type          rsp_meta,
   output logic [VALUE_BITS-1:0] rsp_value
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   state_type             state_ff, state_in;
   logic [CMD_BITS-1:0]   cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] lim_ff, lim_in;
   logic                  cont_ff, cont_in;
   logic [CNT_BITS-1:0]   held_ff, held_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [CNT_BITS-1:0]   lb_ff, lb_in;
   logic                  eq_ff, eq_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   logic [CNT_BITS-1:0]   rd_ptr, wr_ptr;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic                  accept;
   logic                  hit;
   logic                  more;
   logic                  table_full;
   logic                  lb_is_tail;
   logic [CNT_BITS:0]     scan_start;
   logic                  scan_empty;
   logic [COUNT_BITS-1:0] cnt_plus;
   logic                  scan_last;

   assign rd_key     = mem_rd_data[WORD_BITS-1:VALUE_BITS];
   assign rd_val     = mem_rd_data[VALUE_BITS-1:0];
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign hit        = cmp_vld_ff && (key_ff <= rd_key);
   assign more       = (idx_ff < held_ff);
   assign table_full = (held_ff >= CNT_BITS'(CAPACITY));
   assign lb_is_tail = (lb_ff == CNT_BITS'(held_ff - 1'b1));
   assign scan_start = cont_ff ? '0 : ((CNT_BITS + 1)'(lb_ff) + 1'b1);
   assign scan_empty = (cnt_ff >= lim_ff) || (scan_start >= (CNT_BITS + 1)'(held_ff));
   assign cnt_plus   = cnt_ff + 1'b1;
   assign scan_last  = (cnt_plus == lim_ff) || (idx_ff == CNT_BITS'(held_ff - 1'b1));

   assign mem_rd_addr = rd_ptr[IDX_BITS-1:0];
   assign mem_wr_addr = wr_ptr[IDX_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  CMD_FIND, CMD_REMOVE, CMD_UPDATE: state_in = ST_SEARCH;
                  CMD_INSERT: state_in = table_full ? ST_RESP : ST_SEARCH;
                  CMD_SCAN: state_in = req_continue_scan ? ST_DISPATCH : ST_SEARCH;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_SEARCH: begin
            if (hit || !more) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (cmd_ff)
               CMD_INSERT: state_in = (lb_ff == held_ff) ? ST_INS_PUT : ST_INS_SHIFT;
               CMD_REMOVE: state_in = (eq_ff && !lb_is_tail) ? ST_REM_SHIFT : ST_RESP;
               CMD_SCAN: state_in = scan_empty ? ST_RESP : ST_SCAN;
               default: state_in = ST_RESP;
            endcase
         end
         ST_INS_SHIFT: begin
            if (CNT_BITS'(idx_ff - 1'b1) == lb_ff) begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: state_in = ST_RESP;
         ST_REM_SHIFT: begin
            if (CNT_BITS'(idx_ff + 2'd2) == held_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (rsp_free && scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, memory and response controls
   always_comb begin
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      cnt_in     = cnt_ff;
      lim_in     = lim_ff;
      cont_in    = cont_ff;
      held_in    = held_ff;
      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      lb_in      = lb_ff;
      eq_in      = eq_ff;
      status_in  = status_ff;
      mem_rd_en  = 1'b0;
      rd_ptr     = '0;
      mem_wr_en  = 1'b0;
      wr_ptr     = '0;
      mem_wr_data = {key_ff, val_ff};
      rsp_load   = 1'b0;
      rsp_meta   = '0;
      rsp_value  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_command;
               key_in     = req_search_key;
               val_in     = req_new_value;
               cnt_in     = req_count_so_far;
               lim_in     = req_range_limit;
               cont_in    = req_continue_scan;
               idx_in     = '0;
               cmp_vld_in = 1'b0;
               lb_in      = '0;
               eq_in      = 1'b0;
               status_in  = STATUS_DONE;
               if (req_command == CMD_INSERT && table_full) begin
                  status_in = STATUS_NEED_SPLIT;
               end
            end
         end
         ST_SEARCH: begin
            // compare the entry read last cycle while fetching the next one
            if (hit) begin
               lb_in      = cmp_idx_ff;
               eq_in      = (key_ff == rd_key);
               cmp_vld_in = 1'b0;
            end else if (more) begin
               mem_rd_en  = 1'b1;
               rd_ptr     = idx_ff;
               cmp_idx_in = idx_ff;
               cmp_vld_in = 1'b1;
               idx_in     = idx_ff + 1'b1;
            end else begin
               lb_in      = held_ff;
               eq_in      = 1'b0;
               cmp_vld_in = 1'b0;
            end
         end
         ST_DISPATCH: begin
            unique case (cmd_ff)
               CMD_UPDATE: begin
                  if (eq_ff) begin
                     mem_wr_en = 1'b1;
                     wr_ptr    = lb_ff;
                  end else begin
                     status_in = STATUS_NOT_FOUND;
                  end
               end
               CMD_INSERT: begin
                  if (lb_ff != held_ff) begin
                     mem_rd_en = 1'b1;
                     rd_ptr    = CNT_BITS'(held_ff - 1'b1);
                     idx_in    = held_ff;
                  end
               end
               CMD_REMOVE: begin
                  if (!eq_ff) begin
                     status_in = STATUS_NOT_FOUND;
                  end else if (lb_is_tail) begin
                     held_in = held_ff - 1'b1;
                  end else begin
                     mem_rd_en = 1'b1;
                     rd_ptr    = lb_ff + 1'b1;
                     idx_in    = lb_ff;
                  end
               end
               CMD_SCAN: begin
                  if (!scan_empty) begin
                     mem_rd_en = 1'b1;
                     rd_ptr    = scan_start[CNT_BITS-1:0];
                     idx_in    = scan_start[CNT_BITS-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS_SHIFT: begin
            // move entry idx-1 up to idx, fetch idx-2
            mem_wr_en   = 1'b1;
            wr_ptr      = idx_ff;
            mem_wr_data = mem_rd_data;
            if (CNT_BITS'(idx_ff - 1'b1) != lb_ff) begin
               mem_rd_en = 1'b1;
               rd_ptr    = CNT_BITS'(idx_ff - 2'd2);
               idx_in    = idx_ff - 1'b1;
            end
         end
         ST_INS_PUT: begin
            mem_wr_en = 1'b1;
            wr_ptr    = lb_ff;
            held_in   = held_ff + 1'b1;
         end
         ST_REM_SHIFT: begin
            // move entry idx+1 down to idx, fetch idx+2
            mem_wr_en   = 1'b1;
            wr_ptr      = idx_ff;
            mem_wr_data = mem_rd_data;
            if (CNT_BITS'(idx_ff + 2'd2) == held_ff) begin
               held_in = held_ff - 1'b1;
            end else begin
               mem_rd_en = 1'b1;
               rd_ptr    = CNT_BITS'(idx_ff + 2'd2);
               idx_in    = idx_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (rsp_free) begin
               rsp_load               = 1'b1;
               rsp_meta.status        = STATUS_DONE;
               rsp_meta.value_valid   = 1'b1;
               rsp_meta.running_count = cnt_plus;
               rsp_meta.last_result   = scan_last;
               rsp_value              = rd_val;
               cnt_in                 = cnt_plus;
               if (!scan_last) begin
                  mem_rd_en = 1'b1;
                  rd_ptr    = idx_ff + 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_load             = 1'b1;
               rsp_meta.status      = status_ff;
               rsp_meta.last_result = 1'b1;
               if (cmd_ff == CMD_SCAN) begin
                  rsp_meta.running_count = cnt_ff;
               end
               if (cmd_ff == CMD_FIND && eq_ff) begin
                  rsp_value = rd_val;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         held_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         held_ff    <= held_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      cnt_ff     <= cnt_in;
      lim_ff     <= lim_in;
      cont_ff    <= cont_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      lb_ff      <= lb_in;
      eq_ff      <= eq_in;
      status_ff  <= status_in;
   end

endmodule

FILE: src/sorted_leaf_table_core.sv
// sorted leaf table top level: sequencer, entry store and output register
// depends on slt_pkg, slt_req_if, slt_rsp_if, slt_ram, slt_rsp_stage, slt_ctrl
//
// Keeps up to CAPACITY key/value pairs in ascending unsigned key order in
// one single-port-read, single-port-write memory (key and value side by side).
// req_ch carries one command per beat: find, insert, remove, update or range
// scan. rsp_ch returns one beat per command, or one beat per scanned value
// for a range scan; last_result marks the final beat of a command.
// One command is worked on at a time; req_ch.ready is high while the
// sequencer is idle, even when a response beat still waits in the output
// register.
// Sequence, with n entries held and lb the lower-bound position of the key:
//   search walks the memory one entry per cycle up to lb, or through all n
//   entries when the key is above every entry, then dispatches
//   insert shifts entries lb to n - 1 up by one place, then writes at lb
//   remove shifts entries lb + 1 to n - 1 down by one place
//   range scan gives one value per cycle while rsp_ch.ready stays high
//   a single beat is loaded as the sequencer returns to idle
// Reset empties the table; stored entries are not cleared. A stalled
// receiver holds the response beat and the sequencer.
module sorted_leaf_table_core
   import slt_pkg::*;
#(
   parameter int CAPACITY   = 32,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic      clock,
   input  logic      reset,
   slt_req_if.sink   req_ch,
   slt_rsp_if.source rsp_ch
);

   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int WORD_BITS = KEY_BITS + VALUE_BITS;

   logic                  mem_wr_en;
   logic [IDX_BITS-1:0]   mem_wr_addr;
   logic [WORD_BITS-1:0]  mem_wr_data;
   logic                  mem_rd_en;
   logic [IDX_BITS-1:0]   mem_rd_addr;
   logic [WORD_BITS-1:0]  mem_rd_data;
   logic                  rsp_free;
   logic                  rsp_load;
   rsp_meta_type          rsp_meta;
   logic [VALUE_BITS-1:0] rsp_value;

   slt_ctrl #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_command       (req_ch.command),
      .req_search_key    (req_ch.search_key),
      .req_new_value     (req_ch.new_value),
      .req_count_so_far  (req_ch.count_so_far),
      .req_range_limit   (req_ch.range_limit),
      .req_continue_scan (req_ch.continue_scan),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .rsp_free          (rsp_free),
      .rsp_load          (rsp_load),
      .rsp_meta          (rsp_meta),
      .rsp_value         (rsp_value)
   );

   slt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   slt_rsp_stage #(
      .VALUE_BITS (VALUE_BITS)
   ) u_rsp_stage (
      .clock             (clock),
      .reset             (reset),
      .load              (rsp_load),
      .meta              (rsp_meta),
      .value             (rsp_value),
      .free              (rsp_free),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_found_value   (rsp_ch.found_value),
      .rsp_value_valid   (rsp_ch.value_valid),
      .rsp_running_count (rsp_ch.running_count),
      .rsp_last_result   (rsp_ch.last_result)
   );

endmodule

FILE: src/slt_checker.sv
// sorted leaf table: port-level checks, bound to sorted_leaf_table_core
// depends on slt_pkg, slt_req_if, slt_rsp_if
module slt_checker
   import slt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   slt_req_if.sink   req_ch,
   slt_rsp_if.source rsp_ch
);

   // a stalled response beat stays valid and keeps its value and last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.found_value)
         && $stable(rsp_ch.last_result))
      else $error("stalled response beat changed");

   // one command at a time: no request taken right after a request beat
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while busy");

   // no response beat out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response beat after reset");

   // a scanned value beat is a successful one with a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.value_valid |->
         rsp_ch.status == STATUS_DONE && rsp_ch.running_count != 0)
      else $error("bad range value beat");

endmodule

bind sorted_leaf_table_core slt_checker u_slt_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
